FILE: rtl/gesa_pkg.sv
// Shared types and constants of the grouped exponential score accumulator.
`timescale 1ns / 1ps

package gesa_pkg;

   localparam int NUM_FEATURES = 4;
   localparam int NUM_GROUPS   = 64;
   localparam int GROUP_W      = 6;
   localparam int FEAT_W       = 16;
   localparam int COUNT_W      = 16;
   localparam int SCORE_W      = 32;
   localparam int FIDX_W       = 2;
   localparam int ACC_W        = 64;
   localparam int QUOT_W       = 56;
   localparam int PROD_W       = 119;

   localparam logic CMD_ROW  = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
   localparam logic [30:0] PC1 = 31'd746442332;
   localparam logic [30:0] PC2 = 31'd242837236;
   localparam logic [30:0] PC3 = 31'd84462250;
   localparam logic signed [33:0] EXP_LIM = 34'sd201326592;
   localparam logic [82:0] CAP62 = 83'h4000_0000_0000_0000;
   localparam logic signed [64:0] WS_MAX = {2'b00, {63{1'b1}}};
   localparam logic signed [64:0] WS_MIN = -WS_MAX;
   localparam logic signed [64:0] SC_MAX = 65'sh0_7FFF_FFFF;
   localparam logic signed [64:0] SC_MIN = -65'sh0_8000_0000;

   typedef logic signed [FEAT_W-1:0] feat_type;

   typedef struct packed {
      logic                                 is_emit;
      logic [GROUP_W-1:0]                   group;
      logic [NUM_FEATURES-1:0][FEAT_W-1:0]  feat;
      logic [COUNT_W-1:0]                   count;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   typedef struct packed {
      logic [ACC_W-1:0]                     exp_sum;
      logic [NUM_FEATURES-1:0][ACC_W-1:0]   ws;
   } row_type;

   localparam int ROW_W = $bits(row_type);

endpackage

FILE: rtl/gesa_if.sv
// Channel interfaces: row/emit requests, score responses and coefficient writes.
`timescale 1ns / 1ps

interface gesa_req_if;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [5:0]          group_index;
   logic signed [15:0]  feat_0;
   logic signed [15:0]  feat_1;
   logic signed [15:0]  feat_2;
   logic signed [15:0]  feat_3;
   logic [15:0]         observed_count;
   modport source (output valid, cmd, group_index, feat_0, feat_1, feat_2, feat_3,
                   observed_count, input ready);
   modport sink (input valid, cmd, group_index, feat_0, feat_1, feat_2, feat_3,
                 observed_count, output ready);
endinterface

interface gesa_rsp_if;
   logic                valid;
   logic                ready;
   logic [5:0]          out_group;
   logic signed [31:0]  score_0;
   logic signed [31:0]  score_1;
   logic signed [31:0]  score_2;
   logic signed [31:0]  score_3;
   logic                empty_group;
   modport source (output valid, out_group, score_0, score_1, score_2, score_3,
                   empty_group, input ready);
   modport sink (input valid, out_group, score_0, score_1, score_2, score_3,
                 empty_group, output ready);
endinterface

interface gesa_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/gesa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gesa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/gesa_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module gesa_div #(
   parameter int NW = 56,
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] num_ff, num_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      trial   = {rem_ff, num_ff[NW-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         den_in  = divisor;
         num_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         num_in = {num_ff[NW-2:0], 1'b0};
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/gesa_front.sv
// Request front end: accepts items, decodes the command and queues jobs.
`timescale 1ns / 1ps

module gesa_front (
   input  logic              clock,
   input  logic              reset,
   gesa_req_if.sink          req_ch,
   output gesa_pkg::head_type head,
   input  logic              head_pop
);

   gesa_pkg::job_type job_ff [2];
   gesa_pkg::job_type job_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   gesa_pkg::job_type incoming;

   always_comb begin
      incoming.is_emit = (req_ch.cmd == gesa_pkg::CMD_EMIT);
      incoming.group   = req_ch.group_index;
      incoming.feat[0] = req_ch.feat_0;
      incoming.feat[1] = req_ch.feat_1;
      incoming.feat[2] = req_ch.feat_2;
      incoming.feat[3] = req_ch.feat_3;
      incoming.count   = req_ch.observed_count;
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push = req_ch.valid && req_ch.ready;
   assign pop  = head_pop && (count_ff != 2'd0);

   always_comb begin
      job_in    = job_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         job_in[wr_ptr_ff] = incoming;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      job_ff <= job_in;
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.job   = job_ff[rd_ptr_ff];

endmodule

FILE: rtl/gesa_back.sv
// Execution back end: exp of the dot product, period accumulation and score emit.
`timescale 1ns / 1ps

module gesa_back (
   input  logic                        clock,
   input  logic                        reset,
   input  gesa_pkg::feat_type          coef [gesa_pkg::NUM_FEATURES],
   input  gesa_pkg::head_type          head,
   output logic                        head_pop,
   gesa_rsp_if.source                  rsp_ch
);

   localparam int NF = gesa_pkg::NUM_FEATURES;
   localparam int NG = gesa_pkg::NUM_GROUPS;

   localparam logic signed [31:0] LOG2E_Q30_S = gesa_pkg::LOG2E_Q30;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_DOT   = 4'd2;
   localparam logic [3:0] S_LIN   = 4'd3;
   localparam logic [3:0] S_P3    = 4'd4;
   localparam logic [3:0] S_P2    = 4'd5;
   localparam logic [3:0] S_P1    = 4'd6;
   localparam logic [3:0] S_EXP   = 4'd7;
   localparam logic [3:0] S_MULE  = 4'd8;
   localparam logic [3:0] S_ACC   = 4'd9;
   localparam logic [3:0] S_DIV   = 4'd10;
   localparam logic [3:0] S_MAG   = 4'd11;
   localparam logic [3:0] S_MUL   = 4'd12;
   localparam logic [3:0] S_SCORE = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   logic [3:0]               state_ff, state_in;
   gesa_pkg::job_type        job_ff, job_in;
   gesa_pkg::row_type        row_ff, row_in;
   logic [NG-1:0]            occ_ff, occ_in;
   logic signed [31:0]       prod_ff [NF];
   logic signed [31:0]       prod_in [NF];
   logic signed [33:0]       d_ff, d_in;
   logic                     sat_hi_ff, sat_hi_in;
   logic                     sat_lo_ff, sat_lo_in;
   logic signed [29:0]       t_ff, t_in;
   logic signed [5:0]        k_ff, k_in;
   logic [29:0]              q_ff, q_in;
   logic [30:0]              h_ff, h_in;
   logic [31:0]              m_ff, m_in;
   logic [31:0]              e_ff, e_in;
   logic signed [48:0]       px_ff [NF];
   logic signed [48:0]       px_in [NF];
   logic [gesa_pkg::FIDX_W-1:0] j_ff, j_in;
   logic [62:0]              mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [2:0]               mstep_ff, mstep_in;
   logic [63:0]              pp_ff, pp_in;
   logic [1:0]               psh_ff, psh_in;
   logic [gesa_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic signed [31:0]       score_ff [NF];
   logic signed [31:0]       score_in [NF];
   logic                     empty_ff, empty_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [5:0]               rsp_group_ff, rsp_group_in;
   logic signed [31:0]       rsp_score_ff [NF];
   logic signed [31:0]       rsp_score_in [NF];
   logic                     rsp_empty_ff, rsp_empty_in;

   gesa_pkg::row_type        ram_rdata;
   gesa_pkg::row_type        row_new;
   logic                     ram_we;
   logic                     div_start;
   logic                     div_done;
   logic [gesa_pkg::QUOT_W-1:0] div_quot;

   logic signed [33:0]       dot_sum;
   logic signed [28:0]       d_narrow;
   logic signed [60:0]       dl;
   logic [29:0]              q_now;
   logic [30:0]              hq_a;
   logic [29:0]              hq_b;
   logic [60:0]              hq;
   logic [34:0]              e_up;
   logic signed [6:0]        k_down;
   logic [64:0]              es_sum;
   logic signed [64:0]       ws_sum [NF];
   logic signed [63:0]       ws_sel;
   logic [63:0]              ws_abs;
   logic [31:0]              mul_a;
   logic [31:0]              mul_b;
   logic [gesa_pkg::PROD_W-1:0] pp_wide;
   logic [gesa_pkg::PROD_W-1:0] pp_shift;
   logic [82:0]              p_hi;
   logic [62:0]              p_cap;
   logic signed [64:0]       diff;
   logic signed [64:0]       sdiff;
   logic                     occ_now;

   gesa_ram #(
      .WIDTH (gesa_pkg::ROW_W),
      .DEPTH (NG)
   ) u_row_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (job_ff.group),
      .wdata (row_new),
      .raddr (head.job.group),
      .rdata (ram_rdata)
   );

   gesa_div #(
      .NW (gesa_pkg::QUOT_W),
      .DW (gesa_pkg::ACC_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({job_ff.count, 40'd0}),
      .divisor  (ram_rdata.exp_sum),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign head_pop  = (state_ff == S_IDLE) && head.valid;
   assign occ_now   = occ_ff[job_ff.group];
   assign div_start = (state_ff == S_RD) && job_ff.is_emit && occ_now
                      && (ram_rdata.exp_sum != '0);
   assign ram_we    = (state_ff == S_ACC);

   // datapath pieces shared by the sequencer
   always_comb begin
      dot_sum = '0;
      for (int i = 0; i < NF; i++) begin
         dot_sum = dot_sum + 34'(prod_ff[i]);
      end
      d_narrow = d_ff[28:0];
      dl       = d_narrow * LOG2E_Q30_S;
      q_now    = {t_ff[23:0], 6'd0};
      hq_a     = (state_ff == S_P3) ? gesa_pkg::PC3 : h_ff;
      hq_b     = (state_ff == S_P3) ? q_now : q_ff;
      hq       = 61'(hq_a) * 61'(hq_b);
      e_up     = {3'd0, m_ff} << 2'(k_ff - 6'sd14);
      k_down   = 7'sd14 - {k_ff[5], k_ff};
      es_sum   = {1'b0, row_ff.exp_sum} + {33'd0, e_ff};
      row_new.exp_sum = es_sum[64] ? '1 : es_sum[63:0];
      for (int i = 0; i < NF; i++) begin
         ws_sum[i] = {row_ff.ws[i][63], row_ff.ws[i]} + 65'(px_ff[i]);
         if (ws_sum[i] > gesa_pkg::WS_MAX) begin
            row_new.ws[i] = gesa_pkg::WS_MAX[63:0];
         end else if (ws_sum[i] < gesa_pkg::WS_MIN) begin
            row_new.ws[i] = gesa_pkg::WS_MIN[63:0];
         end else begin
            row_new.ws[i] = ws_sum[i][63:0];
         end
      end
      ws_sel   = $signed(row_ff.ws[j_ff]);
      ws_abs   = ws_sel[63] ? 64'(-ws_sel) : ws_sel;
      mul_a    = mstep_ff[1] ? {1'b0, mag_ff[62:32]} : mag_ff[31:0];
      mul_b    = mstep_ff[0] ? {8'd0, div_quot[55:32]} : div_quot[31:0];
      pp_wide  = {55'd0, pp_ff};
      case (psh_ff)
         2'd0:    pp_shift = pp_wide;
         2'd1:    pp_shift = pp_wide << 32;
         default: pp_shift = pp_wide << 64;
      endcase
      p_hi     = acc_ff[118:36];
      p_cap    = (p_hi > gesa_pkg::CAP62) ? gesa_pkg::CAP62[62:0] : p_hi[62:0];
      diff     = $signed({2'd0, p_cap}) - $signed({14'd0, mag_ff[62:12]});
      sdiff    = neg_ff ? -diff : diff;
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      row_in    = row_ff;
      occ_in    = occ_ff;
      prod_in   = prod_ff;
      d_in      = d_ff;
      sat_hi_in = sat_hi_ff;
      sat_lo_in = sat_lo_ff;
      t_in      = t_ff;
      k_in      = k_ff;
      q_in      = q_ff;
      h_in      = h_ff;
      m_in      = m_ff;
      e_in      = e_ff;
      px_in     = px_ff;
      j_in      = j_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      mstep_in  = mstep_ff;
      pp_in     = pp_ff;
      psh_in    = psh_ff;
      acc_in    = acc_ff;
      score_in  = score_ff;
      empty_in  = empty_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_group_in = rsp_group_ff;
      rsp_score_in = rsp_score_ff;
      rsp_empty_in = rsp_empty_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               job_in   = head.job;
               state_in = S_RD;
            end
         end
         S_RD: begin
            row_in = occ_now ? ram_rdata : '0;
            for (int i = 0; i < NF; i++) begin
               prod_in[i] = $signed(job_ff.feat[i]) * coef[i];
            end
            if (!job_ff.is_emit) begin
               state_in = S_DOT;
            end else begin
               empty_in = !occ_now;
               for (int i = 0; i < NF; i++) begin
                  score_in[i] = '0;
               end
               // empty or all-underflow period reports zero scores
               state_in = div_start ? S_DIV : S_OUT;
            end
         end
         S_DOT: begin
            d_in     = dot_sum;
            state_in = S_LIN;
         end
         S_LIN: begin
            sat_hi_in = (d_ff >= gesa_pkg::EXP_LIM);
            sat_lo_in = (d_ff <= -gesa_pkg::EXP_LIM);
            t_in      = dl[59:30];
            state_in  = S_P3;
         end
         S_P3: begin
            k_in     = t_ff[29:24];
            q_in     = q_now;
            h_in     = gesa_pkg::PC2 + hq[60:30];
            state_in = S_P2;
         end
         S_P2: begin
            h_in     = gesa_pkg::PC1 + hq[60:30];
            state_in = S_P1;
         end
         S_P1: begin
            m_in     = 32'h4000_0000 + {1'b0, hq[60:30]};
            state_in = S_EXP;
         end
         S_EXP: begin
            if (sat_hi_ff) begin
               e_in = '1;
            end else if (sat_lo_ff) begin
               e_in = '0;
            end else if (k_ff >= 6'sd14) begin
               e_in = (e_up[34:32] != 3'd0) ? '1 : e_up[31:0];
            end else begin
               e_in = m_ff >> k_down[5:0];
            end
            state_in = S_MULE;
         end
         S_MULE: begin
            for (int i = 0; i < NF; i++) begin
               px_in[i] = $signed(job_ff.feat[i]) * $signed({1'b0, e_ff});
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            occ_in[job_ff.group] = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            if (div_done) begin
               j_in     = '0;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            mag_in   = ws_abs[62:0];
            neg_in   = ws_sel[63];
            acc_in   = '0;
            mstep_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // multiply one partial product while adding the one before
            if (mstep_ff != 3'd4) begin
               pp_in  = mul_a * mul_b;
               psh_in = {1'b0, mstep_ff[1]} + {1'b0, mstep_ff[0]};
            end
            if (mstep_ff != 3'd0) begin
               acc_in = acc_ff + pp_shift;
            end
            mstep_in = mstep_ff + 3'd1;
            if (mstep_ff == 3'd4) begin
               state_in = S_SCORE;
            end
         end
         S_SCORE: begin
            if (sdiff > gesa_pkg::SC_MAX) begin
               score_in[j_ff] = gesa_pkg::SC_MAX[31:0];
            end else if (sdiff < gesa_pkg::SC_MIN) begin
               score_in[j_ff] = gesa_pkg::SC_MIN[31:0];
            end else begin
               score_in[j_ff] = sdiff[31:0];
            end
            if (j_ff == gesa_pkg::FIDX_W'(NF - 1)) begin
               state_in = S_OUT;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_MAG;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_group_in = job_ff.group;
               rsp_score_in = score_ff;
               rsp_empty_in = empty_ff;
               occ_in[job_ff.group] = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff       <= job_in;
      row_ff       <= row_in;
      prod_ff      <= prod_in;
      d_ff         <= d_in;
      sat_hi_ff    <= sat_hi_in;
      sat_lo_ff    <= sat_lo_in;
      t_ff         <= t_in;
      k_ff         <= k_in;
      q_ff         <= q_in;
      h_ff         <= h_in;
      m_ff         <= m_in;
      e_ff         <= e_in;
      px_ff        <= px_in;
      j_ff         <= j_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      mstep_ff     <= mstep_in;
      pp_ff        <= pp_in;
      psh_ff       <= psh_in;
      acc_ff       <= acc_in;
      score_ff     <= score_in;
      empty_ff     <= empty_in;
      rsp_group_ff <= rsp_group_in;
      rsp_score_ff <= rsp_score_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_group   = rsp_group_ff;
   assign rsp_ch.score_0     = rsp_score_ff[0];
   assign rsp_ch.score_1     = rsp_score_ff[1];
   assign rsp_ch.score_2     = rsp_score_ff[2];
   assign rsp_ch.score_3     = rsp_score_ff[3];
   assign rsp_ch.empty_group = rsp_empty_ff;

endmodule

FILE: rtl/grouped_exp_score_accumulator.sv
// Top level of the grouped exponential score accumulator.
//
// Usage: req_ch carries items with valid/ready. A row item (cmd 0) adds
// exp(x . coef), and x times that value per feature, into the accumulators
// of its period. An emit item (cmd 1) returns one score row on rsp_ch and
// clears the period; empty_group marks a period that held no rows.
// csr_ch writes coef_0..coef_3 by index; it is always ready. The user must
// write it only while the block is idle; the block does not enforce this.
// A two-entry queue sits behind req_ch, so items are taken while the engine
// works. A row item passes through the engine in turn: dot product, exp
// polynomial, products, read-modify-write of the period row in a RAM.
// An emit item runs the bit-serial 56-bit division of the count by the exp
// sum, then the split 63 x 56 bit product for each feature, then loads the
// output register.
// A stalled receiver holds the result in the output register; the engine
// waits before loading the next one and the queue fills up behind it.
// Reset clears the coefficients, the period valid bits and all handshakes;
// a period whose valid bit is clear reads as zero, so no clearing pass runs.
`timescale 1ns / 1ps

module grouped_exp_score_accumulator (
   input  logic      clock,
   input  logic      reset,
   gesa_req_if.sink  req_ch,
   gesa_rsp_if.source rsp_ch,
   gesa_csr_if.sink  csr_ch
);

   gesa_pkg::feat_type coef_ff [gesa_pkg::NUM_FEATURES];
   gesa_pkg::feat_type coef_in [gesa_pkg::NUM_FEATURES];
   gesa_pkg::head_type head;
   logic               head_pop;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         coef_in[csr_ch.index] = csr_ch.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gesa_pkg::NUM_FEATURES; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   gesa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .head     (head),
      .head_pop (head_pop)
   );

   gesa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .coef     (coef_ff),
      .head     (head),
      .head_pop (head_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: rtl/gesa_checker.sv
// Port-level checks of the accumulator, bound to the top level.
`timescale 1ns / 1ps

module gesa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_empty,
   input logic [31:0] score_0,
   input logic [31:0] score_1,
   input logic [31:0] score_2,
   input logic [31:0] score_3,
   input logic        csr_ready
);

   // a result waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // an empty period carries zero scores
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> (score_0 == 32'd0) && (score_1 == 32'd0)
                                 && (score_2 == 32'd0) && (score_3 == 32'd0))
      else $error("empty period with nonzero score");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // coefficient port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      $past(csr_ready) |-> csr_ready)
      else $error("coefficient port stalled");

endmodule

bind grouped_exp_score_accumulator gesa_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_empty (rsp_ch.empty_group),
   .score_0   (rsp_ch.score_0),
   .score_1   (rsp_ch.score_1),
   .score_2   (rsp_ch.score_2),
   .score_3   (rsp_ch.score_3),
   .csr_ready (csr_ch.ready)
);

FILE: test/grouped_exp_score_accumulator_test.sv
// Self-checking testbench of the grouped exponential score accumulator.
`timescale 1ns / 1ps

module grouped_exp_score_accumulator_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 150;

   typedef struct {
      logic [5:0]         group;
      logic signed [31:0] score[gesa_pkg::NUM_FEATURES];
      logic               empty;
   } score_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gesa_req_if req_ch();
   gesa_rsp_if rsp_ch();
   gesa_csr_if csr_ch();

   grouped_exp_score_accumulator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // shadow copy of the block state
   logic signed [15:0] coef_mdl[gesa_pkg::NUM_FEATURES];
   logic [63:0]        exp_acc[gesa_pkg::NUM_GROUPS];
   logic signed [63:0] xe_acc[gesa_pkg::NUM_GROUPS][gesa_pkg::NUM_FEATURES];
   bit                 occupied[gesa_pkg::NUM_GROUPS];

   score_row_type pending_scores[$];
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  src_idle_on = 1'b1;
   bit  sink_idle_on = 1'b1;
   int  sink_burst = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = gesa_pkg::CMD_ROW;
      req_ch.group_index = '0;
      req_ch.feat_0 = '0;
      req_ch.feat_1 = '0;
      req_ch.feat_2 = '0;
      req_ch.feat_3 = '0;
      req_ch.observed_count = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("grouped_exp_score_accumulator test failed");
         $finish;
      end
   end

   // receiver drops ready in random bursts while sink idling is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (sink_burst > 0) begin
         sink_burst <= sink_burst - 1;
         rsp_ch.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
         sink_burst <= $urandom_range(0, 2);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
      mismatches++;
   endtask

   always @(posedge clock) begin
      score_row_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_scores.size() == 0) begin
            report("unexpected item", rsp_ch.out_group, 0);
         end else begin
            want = pending_scores.pop_front();
            if (rsp_ch.out_group !== want.group) report("out_group", rsp_ch.out_group, want.group);
            if (rsp_ch.empty_group !== want.empty)
               report("empty_group", rsp_ch.empty_group, want.empty);
            if (rsp_ch.score_0 !== want.score[0]) report("score_0", rsp_ch.score_0, want.score[0]);
            if (rsp_ch.score_1 !== want.score[1]) report("score_1", rsp_ch.score_1, want.score[1]);
            if (rsp_ch.score_2 !== want.score[2]) report("score_2", rsp_ch.score_2, want.score[2]);
            if (rsp_ch.score_3 !== want.score[3]) report("score_3", rsp_ch.score_3, want.score[3]);
         end
      end
   end

   function automatic logic [31:0] exp_approx(input longint d);
      longint t, k;
      logic [63:0] q, h, m, e;
      if (d >= gesa_pkg::EXP_LIM) return 32'hFFFF_FFFF;
      if (d <= -gesa_pkg::EXP_LIM) return 32'h0;
      t = (d * longint'(gesa_pkg::LOG2E_Q30)) >>> 30;
      k = t >>> 24;
      q = 64'(t - (k <<< 24)) << 6;
      h = 64'(gesa_pkg::PC3);
      h = 64'(gesa_pkg::PC2) + ((h * q) >> 30);
      h = 64'(gesa_pkg::PC1) + ((h * q) >> 30);
      m = (64'd1 << 30) + ((h * q) >> 30);
      if (k >= 14) e = m << (k - 14);
      else e = m >> (14 - k);
      return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
   endfunction

   function automatic void accumulate_row(input logic [5:0] g, input logic signed [15:0] x[4]);
      longint d;
      logic [31:0] e;
      logic [64:0] usum;
      logic signed [64:0] ssum;
      longint p;
      d = 0;
      for (int j = 0; j < gesa_pkg::NUM_FEATURES; j++)
         d += longint'(x[j]) * longint'(coef_mdl[j]);
      e = exp_approx(d);
      usum = {1'b0, exp_acc[g]} + {33'b0, e};
      exp_acc[g] = usum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : usum[63:0];
      for (int j = 0; j < gesa_pkg::NUM_FEATURES; j++) begin
         p = longint'(x[j]) * longint'({32'b0, e});
         ssum = 65'(xe_acc[g][j]) + 65'(p);
         if (ssum > gesa_pkg::WS_MAX) ssum = gesa_pkg::WS_MAX;
         if (ssum < gesa_pkg::WS_MIN) ssum = gesa_pkg::WS_MIN;
         xe_acc[g][j] = ssum[63:0];
      end
      occupied[g] = 1'b1;
   endfunction

   function automatic score_row_type emit_scores(input logic [5:0] g, input logic [15:0] y);
      score_row_type r;
      logic [63:0] f, mag, pm;
      logic [127:0] prod;
      longint diff;
      bit neg;
      r.group = g;
      r.empty = !occupied[g];
      for (int j = 0; j < gesa_pkg::NUM_FEATURES; j++) r.score[j] = '0;
      if (occupied[g] && exp_acc[g] != 0) begin
         f = {8'b0, y, 40'b0} / exp_acc[g];
         for (int j = 0; j < gesa_pkg::NUM_FEATURES; j++) begin
            neg = xe_acc[g][j] < 0;
            mag = neg ? -xe_acc[g][j] : xe_acc[g][j];
            prod = {64'b0, mag} * {64'b0, f};
            prod = prod >> 36;
            pm = (prod > (128'd1 << 62)) ? (64'd1 << 62) : prod[63:0];
            diff = longint'(pm) - longint'(mag >> 12);
            if (neg) diff = -diff;
            if (diff > 64'sd2147483647) diff = 64'sd2147483647;
            if (diff < -64'sd2147483648) diff = -64'sd2147483648;
            r.score[j] = diff[31:0];
         end
      end
      exp_acc[g] = '0;
      for (int j = 0; j < gesa_pkg::NUM_FEATURES; j++) xe_acc[g][j] = '0;
      occupied[g] = 1'b0;
      return r;
   endfunction

   task automatic send_item(input logic cmd, input logic [5:0] g, input logic signed [15:0] x[4],
                            input logic [15:0] y);
      if (src_idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.group_index <= g;
      req_ch.feat_0 <= x[0];
      req_ch.feat_1 <= x[1];
      req_ch.feat_2 <= x[2];
      req_ch.feat_3 <= x[3];
      req_ch.observed_count <= y;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (cmd == gesa_pkg::CMD_ROW) accumulate_row(g, x);
      else pending_scores.push_back(emit_scores(g, y));
   endtask

   task automatic send_row(input logic [5:0] g, input logic signed [15:0] x[4]);
      send_item(gesa_pkg::CMD_ROW, g, x, 16'($urandom));
   endtask

   task automatic send_emit(input logic [5:0] g, input logic [15:0] y);
      logic signed [15:0] x[4];
      foreach (x[j]) x[j] = 16'($urandom);
      send_item(gesa_pkg::CMD_EMIT, g, x, y);
   endtask

   // drop valid, wait out every score and the engine's tail of row work
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(input int idx, input logic signed [15:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx[1:0];
      csr_ch.data <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      coef_mdl[idx] = v;
   endtask

   task automatic load_coefs(input logic signed [15:0] c0, c1, c2, c3);
      settle();
      write_coef(0, c0);
      write_coef(1, c1);
      write_coef(2, c2);
      write_coef(3, c3);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_feat();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'sh7FFF - 16'($urandom_range(0, 3));
         2: return 16'sh8000 + 16'($urandom_range(0, 3));
         default: return 16'($signed($urandom_range(0, 8192)) - 4096);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'sh7FFF;
         2: return 16'sh8000;
         default: return 16'($signed($urandom_range(0, 2048)) - 1024);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [15:0] x[4];
      // zero coefficients: every row gives exp of zero
      x = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
      send_row(6'd0, x);
      x = '{16'sh8000, 16'sh7FFF, 16'sh1000, 16'sh0001};
      send_row(6'd0, x);
      send_emit(6'd0, 16'hFFFF);
      x = '{16'sh1000, 16'sh2000, 16'shF000, 16'sh0000};
      send_row(6'd63, x);
      send_emit(6'd63, 16'h0000);
      // never-used period and re-emit of a cleared one
      send_emit(6'd17, 16'd5);
      send_emit(6'd0, 16'd5);
      // exp saturates high
      load_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      x = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      send_row(6'd5, x);
      send_row(6'd5, x);
      x = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      send_row(6'd6, x);
      send_emit(6'd5, 16'hFFFF);
      send_emit(6'd6, 16'd1);
      // exp underflows to zero: rows present but exp sum zero
      load_coefs(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      x = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      send_row(6'd9, x);
      send_row(6'd9, x);
      send_emit(6'd9, 16'd100);
      send_emit(6'd9, 16'd100);
      // mixed signs near the exp limits
      load_coefs(16'sh1000, 16'shF000, 16'sh0800, 16'sh0000);
      x = '{16'sh3000, 16'sh1000, 16'shE000, 16'sh7FFF};
      send_row(6'd33, x);
      x = '{16'shB000, 16'sh4000, 16'sh2000, 16'sh8000};
      send_row(6'd33, x);
      send_emit(6'd33, 16'd3);
      settle();
   endtask

   // sessions of rows into a few periods, then their emits; some noise
   task automatic random_sessions(input int n_items);
      logic signed [15:0] x[4];
      logic [5:0] groups[4];
      int ng, sent;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0)
            load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
         if ($urandom_range(0, 29) == 0) settle();
         ng = $urandom_range(1, 4);
         for (int i = 0; i < ng; i++) groups[i] = 6'($urandom);
         repeat ($urandom_range(1, 12)) begin
            foreach (x[j]) x[j] = rand_feat();
            send_row(groups[$urandom_range(0, ng - 1)], x);
            sent++;
         end
         if ($urandom_range(0, 4) == 0) begin
            send_emit(6'($urandom), 16'($urandom));
            sent++;
         end
         for (int i = 0; i < ng; i++) begin
            send_emit(groups[i], ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 20)));
            sent++;
         end
      end
      settle();
   endtask

   task automatic test_random();
      random_sessions(600);
   endtask

   task automatic test_no_idle();
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
      random_sessions(100);
   endtask

   initial begin
      foreach (coef_mdl[j]) coef_mdl[j] = '0;
      foreach (exp_acc[g]) begin
         exp_acc[g] = '0;
         occupied[g] = 1'b0;
         foreach (xe_acc[g][j]) xe_acc[g][j] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_no_idle();
      if (mismatches == 0) begin
         $display("grouped_exp_score_accumulator test passed");
      end else begin
         $display("grouped_exp_score_accumulator test failed");
      end
      $finish;
   end

endmodule
